>>> rtl/hcbc_pkg.sv
`timescale 1ns / 1ps
// Package for the HSV color blob centroid block: widths, limits, register
// indexes and reset values, and the controller-to-datapath command types.
// No dependencies.
package hcbc_pkg;

  localparam int MAX_ROW_PIXELS = 4096;
  localparam int MAX_ROWS       = 4096;

  localparam int PIX_W   = 32;
  localparam int POS_W   = 12;
  localparam int WIDTH_W = 13;
  localparam int SUM_W   = 36;
  localparam int CNT_W   = 25;
  localparam int HUE_W   = 9;
  localparam int SAT_W   = 7;
  localparam int VAL_W   = 8;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 13;

  localparam int DIV_STEPS  = SUM_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam logic [IDX_W-1:0] REG_ROW_WIDTH = 3'd0;
  localparam logic [IDX_W-1:0] REG_HUE_LOW   = 3'd1;
  localparam logic [IDX_W-1:0] REG_HUE_HIGH  = 3'd2;
  localparam logic [IDX_W-1:0] REG_SAT_MIN   = 3'd3;
  localparam logic [IDX_W-1:0] REG_VALUE_MIN = 3'd4;

  localparam logic [WIDTH_W-1:0] ROW_WIDTH_RST = 13'd640;
  localparam logic [HUE_W-1:0]   HUE_LOW_RST   = 9'd25;
  localparam logic [HUE_W-1:0]   HUE_HIGH_RST  = 9'd45;
  localparam logic [SAT_W-1:0]   SAT_MIN_RST   = 7'd40;
  localparam logic [VAL_W-1:0]   VALUE_MIN_RST = 8'd127;

  typedef struct packed {
    logic s1_load;
    logic emit;
    logic acc;
    logic div_load;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic s1_last;
  } status_t;

endpackage

>>> rtl/hsv_color_blob_centroid.sv
`timescale 1ns / 1ps
// Ordinary pixels pass through the input word register and then the output word
// register, one pixel per cycle sustained while the output side is not stalled.
// A frame-end pixel's word follows accumulate, divider load, 36 steps of two
// parallel restoring dividers and the output write; the input stalls meanwhile.
// Reset: synchronous, clears control, counters, sums and centroid; registers
// return to their defaults. No clearing pass. Uses hcbc_pkg.
module hsv_color_blob_centroid (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hcbc_pkg::PIX_W-1:0]    pixel_in,
  input  logic                          frame_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hcbc_pkg::PIX_W-1:0]    pixel_out,
  output logic                          matched,
  output logic                          end_of_frame,
  output logic [hcbc_pkg::POS_W-1:0]    centroid_x,
  output logic [hcbc_pkg::POS_W-1:0]    centroid_y,
  output logic                          centroid_found,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hcbc_pkg::IDX_W-1:0]    cfg_index,
  input  logic [hcbc_pkg::DATA_W-1:0]   cfg_data
);
  import hcbc_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  hcbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  hcbc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .pixel_in       (pixel_in),
    .frame_last     (frame_last),
    .cfg_write      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pixel_out      (pixel_out),
    .matched        (matched),
    .end_of_frame   (end_of_frame),
    .centroid_x     (centroid_x),
    .centroid_y     (centroid_y),
    .centroid_found (centroid_found)
  );

endmodule

>>> rtl/hcbc_dp.sv
`timescale 1ns / 1ps
// Datapath: configuration registers, pixel classifier, position counters,
// sums, two restoring dividers and the output word. Depends on hcbc_pkg.
module hcbc_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  hcbc_pkg::cmd_t                cmd,
  output hcbc_pkg::status_t             status,
  input  logic [hcbc_pkg::PIX_W-1:0]    pixel_in,
  input  logic                          frame_last,
  input  logic                          cfg_write,
  input  logic [hcbc_pkg::IDX_W-1:0]    cfg_index,
  input  logic [hcbc_pkg::DATA_W-1:0]   cfg_data,
  output logic [hcbc_pkg::PIX_W-1:0]    pixel_out,
  output logic                          matched,
  output logic                          end_of_frame,
  output logic [hcbc_pkg::POS_W-1:0]    centroid_x,
  output logic [hcbc_pkg::POS_W-1:0]    centroid_y,
  output logic                          centroid_found
);
  import hcbc_pkg::*;

  logic [WIDTH_W-1:0] row_width;
  logic [HUE_W-1:0]   hue_low_deg;
  logic [HUE_W-1:0]   hue_high_deg;
  logic [SAT_W-1:0]   sat_min_percent;
  logic [VAL_W-1:0]   value_min;

  logic [PIX_W-1:0]   s1_pixel;
  logic               s1_last;

  logic [POS_W-1:0]   column_count;
  logic [POS_W-1:0]   row_count;
  logic [SUM_W-1:0]   sum_columns;
  logic [SUM_W-1:0]   sum_rows;
  logic [CNT_W-1:0]   match_count;

  logic [CNT_W-1:0]   rem_x, rem_y;
  logic [SUM_W-1:0]   quo_x, quo_y;
  logic [CNT_W:0]     shift_x, shift_y;
  logic [CNT_W:0]     trial_x, trial_y;

  logic [7:0]         r, g, b, mx, mn, d;
  logic [14:0]        sat_lhs, sat_rhs;
  logic signed [18:0] n, lo_n, hi_n, dd;
  logic               hit;

  logic [WIDTH_W-1:0] width_eff;
  logic [POS_W:0]     col_inc, row_inc;
  logic               found;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width       <= ROW_WIDTH_RST;
      hue_low_deg     <= HUE_LOW_RST;
      hue_high_deg    <= HUE_HIGH_RST;
      sat_min_percent <= SAT_MIN_RST;
      value_min       <= VALUE_MIN_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROW_WIDTH: row_width       <= cfg_data;
        REG_HUE_LOW:   hue_low_deg     <= cfg_data[HUE_W-1:0];
        REG_HUE_HIGH:  hue_high_deg    <= cfg_data[HUE_W-1:0];
        REG_SAT_MIN:   sat_min_percent <= cfg_data[SAT_W-1:0];
        REG_VALUE_MIN: value_min       <= cfg_data[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.s1_load) begin
      s1_pixel <= pixel_in;
      s1_last  <= frame_last;
    end
  end

  assign status.s1_last = s1_last;

  always_comb begin
    r  = s1_pixel[23:16];
    g  = s1_pixel[15:8];
    b  = s1_pixel[7:0];
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d  = mx - mn;
    dd = signed'({11'b0, d});
    sat_lhs = {7'b0, d} * 15'd100;
    sat_rhs = {8'b0, sat_min_percent} * {7'b0, mx};
    if (r == mx) begin
      n = 19'sd60 * (signed'({11'b0, g}) - signed'({11'b0, b}));
      if (n < 0) n = n + 19'sd360 * dd;
    end else if (g == mx) begin
      n = 19'sd120 * dd + 19'sd60 * (signed'({11'b0, b}) - signed'({11'b0, r}));
    end else begin
      n = 19'sd240 * dd + 19'sd60 * (signed'({11'b0, r}) - signed'({11'b0, g}));
    end
    lo_n = signed'({10'b0, hue_low_deg}) * dd;
    hi_n = signed'({10'b0, hue_high_deg}) * dd;
    hit  = (sat_lhs > sat_rhs) && (mx > value_min) && (n > lo_n) && (n < hi_n);
  end

  always_comb begin
    if (row_width == '0) width_eff = WIDTH_W'(1);
    else if (row_width > WIDTH_W'(MAX_ROW_PIXELS)) width_eff = WIDTH_W'(MAX_ROW_PIXELS);
    else width_eff = row_width;
    col_inc = {1'b0, column_count} + 13'd1;
    row_inc = {1'b0, row_count} + 13'd1;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      column_count <= '0;
      row_count    <= '0;
      sum_columns  <= '0;
      sum_rows     <= '0;
      match_count  <= '0;
    end else if (cmd.acc) begin
      if (hit) begin
        sum_columns <= sum_columns + {24'b0, column_count};
        sum_rows    <= sum_rows + {24'b0, row_count};
        match_count <= match_count + CNT_W'(1);
      end
      if (col_inc >= width_eff) begin
        column_count <= '0;
        if (row_inc >= 13'(MAX_ROWS)) row_count <= '0;
        else row_count <= row_inc[POS_W-1:0];
      end else begin
        column_count <= col_inc[POS_W-1:0];
      end
    end
  end

  always_comb begin
    shift_x = {rem_x, quo_x[SUM_W-1]};
    shift_y = {rem_y, quo_y[SUM_W-1]};
    trial_x = shift_x - {1'b0, match_count};
    trial_y = shift_y - {1'b0, match_count};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_x <= '0;
      rem_y <= '0;
      quo_x <= sum_columns;
      quo_y <= sum_rows;
    end else if (cmd.div_step) begin
      if (shift_x >= {1'b0, match_count}) begin
        rem_x <= trial_x[CNT_W-1:0];
        quo_x <= {quo_x[SUM_W-2:0], 1'b1};
      end else begin
        rem_x <= shift_x[CNT_W-1:0];
        quo_x <= {quo_x[SUM_W-2:0], 1'b0};
      end
      if (shift_y >= {1'b0, match_count}) begin
        rem_y <= trial_y[CNT_W-1:0];
        quo_y <= {quo_y[SUM_W-2:0], 1'b1};
      end else begin
        rem_y <= shift_y[CNT_W-1:0];
        quo_y <= {quo_y[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign found = cmd.finish && (match_count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      centroid_x <= '0;
      centroid_y <= '0;
    end else if (found) begin
      centroid_x <= quo_x[POS_W-1:0];
      centroid_y <= quo_y[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pixel_out      <= hit ? (s1_pixel | 32'h00FF_0000) : s1_pixel;
      matched        <= hit;
      end_of_frame   <= s1_last;
      centroid_found <= found;
    end
  end

endmodule

>>> rtl/hcbc_ctrl.sv
`timescale 1ns / 1ps
// Controller: input and output word occupancy, the frame-end sequence and the
// divider step count. Depends on hcbc_pkg.
module hcbc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  hcbc_pkg::status_t status,
  output hcbc_pkg::cmd_t    cmd
);
  import hcbc_pkg::*;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]        state, state_next;
  logic [STEP_W-1:0] step;
  logic              s1_valid;
  logic              out_free;
  logic              consume;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    consume      = 1'b0;
    unique case (state)
      ST_RUN: begin
        if (s1_valid && status.s1_last) begin
          cmd.acc    = 1'b1;
          state_next = ST_LOAD;
        end else if (s1_valid && out_free) begin
          cmd.acc  = 1'b1;
          cmd.emit = 1'b1;
          consume  = 1'b1;
        end
      end
      ST_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          cmd.finish = 1'b1;
          consume    = 1'b1;
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
    in_stall    = !((state == ST_RUN) && (!s1_valid || consume));
    cmd.s1_load = in_valid && !in_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      step      <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.div_load) step <= '0;
      else if (cmd.div_step) step <= step + STEP_W'(1);
      if (cmd.s1_load) s1_valid <= 1'b1;
      else if (consume) s1_valid <= 1'b0;
      if (cmd.emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("result word written over an undelivered word");

  a_accept_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.s1_load && s1_valid) |-> consume)
    else $error("input word accepted over a held word");

  a_load_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |=> (state == ST_DIV && step == '0))
    else $error("divider start lost");

  a_div_last: assert property (@(posedge clk) disable iff (rst)
    cmd.div_load |-> (s1_valid && status.s1_last))
    else $error("division started without a frame-end word");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for hsv_color_blob_centroid: a directed table, then
// random frames under several register settings, checked by an HSV predictor.
// Depends on hcbc_pkg and the hsv_color_blob_centroid RTL.
module tb_top;
  import hcbc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 60;
  localparam int DIRECTED_N     = 16;
  localparam int PHASE_N        = 9;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             hit;
    logic             eof;
    logic [POS_W-1:0] cx;
    logic [POS_W-1:0] cy;
    logic             found;
  } pixel_result_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
    logic             typed;
    pixel_result_t    want;
  } stim_row_t;

  typedef struct {
    int rw;
    int lo;
    int hi;
    int sat;
    int val;
    int items;
  } phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [PIX_W-1:0] pixel_in = '0;
  logic frame_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PIX_W-1:0] pixel_out;
  logic matched;
  logic end_of_frame;
  logic [POS_W-1:0] centroid_x;
  logic [POS_W-1:0] centroid_y;
  logic centroid_found;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  // Predictor copy of the registers and the frame state.
  logic [WIDTH_W-1:0] cfg_row_width;
  logic [HUE_W-1:0] cfg_hue_lo;
  logic [HUE_W-1:0] cfg_hue_hi;
  logic [SAT_W-1:0] cfg_sat;
  logic [VAL_W-1:0] cfg_val;
  logic [POS_W-1:0] col_pos;
  logic [POS_W-1:0] row_pos;
  logic [SUM_W-1:0] sum_x;
  logic [SUM_W-1:0] sum_y;
  logic [CNT_W-1:0] hit_count;
  logic [POS_W-1:0] cen_x;
  logic [POS_W-1:0] cen_y;

  pixel_result_t pending_results[$];
  int bad_words = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int idle_cycles;

  stim_row_t directed_rows [DIRECTED_N];
  phase_t phase_plan [PHASE_N] = '{
    '{0,    0,   511, 0,   0,   60},
    '{8191, 340, 360, 100, 255, 40},
    '{5,    200, 100, 20,  50,  50},
    '{3,    330, 360, 30,  100, 60},
    '{4096, 100, 260, 50,  60,  60},
    '{1,    25,  45,  40,  127, 60},
    '{7,    0,   180, 10,  20,  70},
    '{2,    180, 360, 60,  0,   70},
    '{6,    60,  300, 99,  254, 60}
  };

  hsv_color_blob_centroid i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .pixel_in       (pixel_in),
    .frame_last     (frame_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pixel_out      (pixel_out),
    .matched        (matched),
    .end_of_frame   (end_of_frame),
    .centroid_x     (centroid_x),
    .centroid_y     (centroid_y),
    .centroid_found (centroid_found),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic color_hit(input int r, input int g, input int b);
    int mx;
    int mn;
    int d;
    int n;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    if (!(d * 100 > int'(cfg_sat) * mx)) return 1'b0;
    if (!(mx > int'(cfg_val))) return 1'b0;
    if (r == mx) begin
      n = 60 * (g - b);
      if (n < 0) n = n + 360 * d;
    end else if (g == mx) begin
      n = 120 * d + 60 * (b - r);
    end else begin
      n = 240 * d + 60 * (r - g);
    end
    return (n > int'(cfg_hue_lo) * d) && (n < int'(cfg_hue_hi) * d);
  endfunction

  function automatic pixel_result_t predict_pixel(input logic [PIX_W-1:0] pix,
                                                  input logic last);
    pixel_result_t res;
    logic hit;
    int w;
    int next_col;
    hit = color_hit(int'(pix[23:16]), int'(pix[15:8]), int'(pix[7:0]));
    w = int'(cfg_row_width);
    if (w == 0) w = 1;
    if (w > MAX_ROW_PIXELS) w = MAX_ROW_PIXELS;
    res.pixel = pix;
    res.found = 1'b0;
    if (hit) begin
      res.pixel[23:16] = 8'hFF;
      sum_x = sum_x + SUM_W'(col_pos);
      sum_y = sum_y + SUM_W'(row_pos);
      hit_count = hit_count + 1'b1;
    end
    next_col = int'(col_pos) + 1;
    if (next_col >= w) begin
      col_pos = '0;
      if (int'(row_pos) + 1 >= MAX_ROWS) row_pos = '0;
      else row_pos = row_pos + 1'b1;
    end else begin
      col_pos = POS_W'(next_col);
    end
    if (last) begin
      if (hit_count != 0) begin
        cen_x = POS_W'(sum_x / SUM_W'(hit_count));
        cen_y = POS_W'(sum_y / SUM_W'(hit_count));
        res.found = 1'b1;
      end
      col_pos = '0;
      row_pos = '0;
      sum_x = '0;
      sum_y = '0;
      hit_count = '0;
    end
    res.hit = hit;
    res.eof = last;
    res.cx = cen_x;
    res.cy = cen_y;
    return res;
  endfunction

  // Mostly pixels built to pass the saturation and value tests, with a random
  // hue, plus grey pixels and raw noise.
  function automatic logic [PIX_W-1:0] make_pixel();
    int pick;
    int mx;
    int d;
    int dmin;
    int mn;
    int mid;
    int hi_ch;
    int lo_ch;
    logic [7:0] ch [3];
    logic [7:0] top;
    pick = $urandom_range(99);
    top = 8'($urandom);
    if (pick < 15) begin
      ch[0] = 8'($urandom);
      return {top, ch[0], ch[0], ch[0]};
    end
    if (pick < 45) return $urandom;
    if (cfg_val < 8'd255) mx = $urandom_range(255, int'(cfg_val) + 1);
    else mx = $urandom_range(255);
    dmin = int'(cfg_sat) * mx / 100 + 1;
    if (dmin > mx) d = $urandom_range(mx);
    else d = $urandom_range(mx, dmin);
    mn = mx - d;
    mid = $urandom_range(mx, mn);
    hi_ch = $urandom_range(2);
    lo_ch = (hi_ch + 1 + $urandom_range(1)) % 3;
    ch[hi_ch] = 8'(mx);
    ch[lo_ch] = 8'(mn);
    ch[3 - hi_ch - lo_ch] = 8'(mid);
    return {top, ch[0], ch[1], ch[2]};
  endfunction

  task automatic send_word(input logic [PIX_W-1:0] pix, input logic last,
                           input logic typed, input pixel_result_t want);
    pixel_result_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_in <= pix;
    frame_last <= last;
    do @(posedge clk); while (in_stall);
    res = predict_pixel(pix, last);
    pending_results.push_back(typed ? want : res);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic program_regs(input int rw, input int lo, input int hi,
                              input int sat, input int val);
    logic [IDX_W-1:0] idx [5];
    int data [5];
    idx = '{REG_ROW_WIDTH, REG_HUE_LOW, REG_HUE_HIGH, REG_SAT_MIN, REG_VALUE_MIN};
    data = '{rw, lo, hi, sat, val};
    for (int k = 0; k < 5; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= DATA_W'(data[k]);
      do @(posedge clk); while (!cfg_ready);
      case (idx[k])
        REG_ROW_WIDTH: cfg_row_width = WIDTH_W'(data[k]);
        REG_HUE_LOW:   cfg_hue_lo = HUE_W'(data[k]);
        REG_HUE_HIGH:  cfg_hue_hi = HUE_W'(data[k]);
        REG_SAT_MIN:   cfg_sat = SAT_W'(data[k]);
        REG_VALUE_MIN: cfg_val = VAL_W'(data[k]);
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    pixel_result_t got;
    pixel_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{pixel_out, matched, end_of_frame, centroid_x, centroid_y, centroid_found};
      if (pending_results.size() == 0) begin
        bad_words++;
        if (bad_words <= 10) $display("t=%0t unexpected result word %h", $realtime, got);
      end else begin
        want = pending_results.pop_front();
        if (got.pixel !== want.pixel || got.hit !== want.hit || got.eof !== want.eof ||
            got.cx !== want.cx || got.cy !== want.cy || got.found !== want.found) begin
          bad_words++;
          if (bad_words <= 10) begin
            $display("t=%0t word error: expected pix %h hit %b eof %b cx %0d cy %0d found %b",
                     $realtime, want.pixel, want.hit, want.eof, want.cx, want.cy, want.found);
            $display("t=%0t              got pix %h hit %b eof %b cx %0d cy %0d found %b",
                     $realtime, got.pixel, got.hit, got.eof, got.cx, got.cy, got.found);
          end
        end
      end
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int sent;
    int len;
    pixel_result_t none;
    none = '0;
    directed_rows = '{
      '{32'h00000000, 1'b0, 1'b1, '{32'h00000000, 1'b0, 1'b0, 12'd0, 12'd0, 1'b0}},
      '{32'hFFFFFFFF, 1'b0, 1'b1, '{32'hFFFFFFFF, 1'b0, 1'b0, 12'd0, 12'd0, 1'b0}},
      '{32'h12C86400, 1'b0, 1'b1, '{32'h12FF6400, 1'b1, 1'b0, 12'd0, 12'd0, 1'b0}},
      '{32'h00000000, 1'b1, 1'b1, '{32'h00000000, 1'b0, 1'b1, 12'd2, 12'd0, 1'b1}},
      '{32'h00808080, 1'b1, 1'b1, '{32'h00808080, 1'b0, 1'b1, 12'd2, 12'd0, 1'b0}},
      '{32'h007F3F00, 1'b0, 1'b0, '0},
      '{32'hA5804000, 1'b0, 1'b0, '0},
      '{32'h00FFC8B4, 1'b0, 1'b0, '0},
      '{32'h0000FF00, 1'b0, 1'b0, '0},
      '{32'h000000FF, 1'b0, 1'b0, '0},
      '{32'h00FF0080, 1'b0, 1'b0, '0},
      '{32'h00E6B400, 1'b0, 1'b0, '0},
      '{32'h00FF6A00, 1'b0, 1'b0, '0},
      '{32'h00FF6B00, 1'b0, 1'b0, '0},
      '{32'h00808000, 1'b1, 1'b0, '0},
      '{32'hFFFF0000, 1'b1, 1'b0, '0}
    };
    cfg_row_width = ROW_WIDTH_RST;
    cfg_hue_lo = HUE_LOW_RST;
    cfg_hue_hi = HUE_HIGH_RST;
    cfg_sat = SAT_MIN_RST;
    cfg_val = VALUE_MIN_RST;
    col_pos = '0;
    row_pos = '0;
    sum_x = '0;
    sum_y = '0;
    hit_count = '0;
    cen_x = '0;
    cen_y = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 17;
    rx_idle_pct <= 50;
    for (int i = 0; i < DIRECTED_N; i++) begin
      send_word(directed_rows[i].pixel, directed_rows[i].last,
                directed_rows[i].typed, directed_rows[i].want);
    end
    drain();

    for (int p = 0; p < PHASE_N; p++) begin
      tx_idle_pct = (p < 3) ? 17 : (p < 6) ? 50 : 0;
      rx_idle_pct <= (p < 3) ? 50 : (p < 6) ? 17 : 0;
      program_regs(phase_plan[p].rw, phase_plan[p].lo, phase_plan[p].hi,
                   phase_plan[p].sat, phase_plan[p].val);
      if (p == 4) hold_requests <= hold_requests + 1;
      sent = 0;
      while (sent < phase_plan[p].items) begin
        len = $urandom_range(24, 1);
        for (int k = 0; k < len; k++) begin
          if (p == 6 && sent == 35) drain();
          send_word(make_pixel(), k == len - 1, 1'b0, none);
          sent++;
        end
      end
      drain();
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (bad_words == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
